// ===== sv/mcst_pkg.sv =====
// mcst_pkg: shared constants and types for the stepper tone engine
// no dependencies; used by the interfaces, the channel unit and the top level
`default_nettype none

package mcst_pkg;

   // channel count and field widths
   localparam int CHANNELS    = 6;
   localparam int CH_W        = 3;
   localparam int ELAPSED_W   = 16;
   localparam int PERIOD_IN_W = 20;
   localparam int PERIOD_W    = 21;
   localparam int COUNT_W     = 22;
   localparam int POS_W       = 8;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_METHOD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_POSITION = 2'd1;

   localparam logic [POS_W-1:0] MAX_POSITION_RESET = 8'd72;

   // request opcodes
   localparam logic OP_TICK       = 1'b0;
   localparam logic OP_SET_PERIOD = 1'b1;

   // step methods
   localparam logic METHOD_SLIDING     = 1'b0;
   localparam logic METHOD_OSCILLATING = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // control broadcast from the top level to every channel unit
   typedef struct packed {
      logic                   tick;
      logic                   set_period;
      logic [CH_W-1:0]        channel;
      logic                   step_method;
      logic [POS_W-1:0]       max_position;
      logic [ELAPSED_W-1:0]   elapsed;
      logic [PERIOD_IN_W-1:0] period_value;
   } chan_ctrl_type;

endpackage : mcst_pkg

`default_nettype wire

// ===== sv/mcst_ifs.sv =====
// mcst_ifs: request, response and configuration channel interfaces
// depends on mcst_pkg for field widths
`default_nettype none

interface mcst_req_if;
   logic                            valid;
   logic                            ready;
   logic                            opcode;
   logic [mcst_pkg::ELAPSED_W-1:0]   elapsed;
   logic [mcst_pkg::CH_W-1:0]        channel;
   logic [mcst_pkg::PERIOD_IN_W-1:0] period_value;

   modport source (output valid, opcode, elapsed, channel, period_value, input ready);
   modport sink   (input valid, opcode, elapsed, channel, period_value, output ready);
endinterface : mcst_req_if

interface mcst_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mcst_pkg::CHANNELS-1:0] step_levels;
   logic [mcst_pkg::CHANNELS-1:0] direction_levels;
   logic [mcst_pkg::CHANNELS-1:0] led_levels;

   modport source (output valid, step_levels, direction_levels, led_levels, input ready);
   modport sink   (input valid, step_levels, direction_levels, led_levels, output ready);
endinterface : mcst_rsp_if

interface mcst_csr_if;
   logic                           valid;
   logic                           ready;
   logic [mcst_pkg::CSR_IDX_W-1:0]  index;
   logic [mcst_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface : mcst_csr_if

`default_nettype wire

// ===== sv/mcst_channel.sv =====
// mcst_channel: per-channel period, counter, step/direction/led state
// depends on mcst_pkg; instantiated once per channel by the top level
`default_nettype none

module mcst_channel (
   input  wire                       clock,
   input  wire                       reset,
   input  wire [mcst_pkg::CH_W-1:0]  chan_id,
   input  wire mcst_pkg::chan_ctrl_type ctrl,
   output logic                      step_level,
   output logic                      direction,
   output logic                      led
);
   import mcst_pkg::*;

   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [COUNT_W-1:0]  count_ff,  count_in;
   logic [POS_W-1:0]    pos_ff,    pos_in;
   logic                dir_ff,    dir_in;
   logic                step_ff,   step_in;
   logic                led_ff,    led_in;

   logic                set_here;
   logic [COUNT_W:0]    sum;
   logic [COUNT_W-1:0]  count_sat;
   logic                fire;
   logic                slide_dir;
   logic                slide_step;

   assign set_here = ctrl.set_period && (ctrl.channel == chan_id);

   // saturating counter add and period compare
   assign sum       = {1'b0, count_ff} + (COUNT_W+1)'(ctrl.elapsed);
   assign count_sat = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
   assign fire      = count_sat >= COUNT_W'(period_ff);

   // sliding direction: turn at the track ends
   always_comb begin
      if (pos_ff >= ctrl.max_position) begin
         slide_dir = 1'b1;
      end else if (pos_ff == '0) begin
         slide_dir = 1'b0;
      end else begin
         slide_dir = dir_ff;
      end
   end
   assign slide_step = ~step_ff;

   // next state
   always_comb begin
      period_in = period_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      dir_in    = dir_ff;
      step_in   = step_ff;
      led_in    = led_ff;
      if (set_here) begin
         if (ctrl.step_method == METHOD_OSCILLATING) begin
            period_in = {1'b0, ctrl.period_value};
         end else begin
            period_in = {ctrl.period_value, 1'b0};
         end
         led_in = (ctrl.period_value != '0);
      end else if (ctrl.tick && (period_ff != '0)) begin
         if (fire) begin
            count_in = '0;
            if (ctrl.step_method == METHOD_OSCILLATING) begin
               if (step_ff) begin
                  dir_in = ~dir_ff;
               end
               step_in = ~step_ff;
            end else begin
               dir_in  = slide_dir;
               step_in = slide_step;
               if (slide_step) begin
                  pos_in = slide_dir ? pos_ff - POS_W'(1) : pos_ff + POS_W'(1);
               end
            end
         end else begin
            count_in = count_sat;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= '0;
         count_ff  <= '0;
         pos_ff    <= '0;
         dir_ff    <= 1'b0;
         step_ff   <= 1'b0;
         led_ff    <= 1'b0;
      end else begin
         period_ff <= period_in;
         count_ff  <= count_in;
         pos_ff    <= pos_in;
         dir_ff    <= dir_in;
         step_ff   <= step_in;
         led_ff    <= led_in;
      end
   end

   assign step_level = step_ff;
   assign direction  = dir_ff;
   assign led        = led_ff;

endmodule : mcst_channel

`default_nettype wire

// ===== sv/multi_channel_stepper_tone_engine.sv =====
// request path: an accepted request waits in the request register until it advances, which updates
// the channel state; its pin levels then appear on rsp together with rsp valid
// throughput: one request per cycle while rsp is taken; the channel state registers double as the
// result register, and the request register takes a new request while a result waits
// reset: synchronous, clears all channel state, step_method to sliding, max_position to 72
// depends on mcst_pkg, mcst_ifs and mcst_channel
`default_nettype none

module multi_channel_stepper_tone_engine (
   input wire          clock,
   input wire          reset,
   mcst_req_if.sink    req_ch,
   mcst_rsp_if.source  rsp_ch,
   mcst_csr_if.sink    csr_ch
);
   import mcst_pkg::*;

   // request register
   logic                   req_valid_ff, req_valid_in;
   logic                   opcode_ff;
   logic [ELAPSED_W-1:0]   elapsed_ff;
   logic [CH_W-1:0]        channel_ff;
   logic [PERIOD_IN_W-1:0] period_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   method_ff;
   logic [POS_W-1:0]       max_pos_ff;

   logic                   advance;
   logic                   req_fire;
   chan_ctrl_type          ctrl;

   logic [CHANNELS-1:0]    step_bits;
   logic [CHANNELS-1:0]    dir_bits;
   logic [CHANNELS-1:0]    led_bits;

   // handshake
   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !reset && (!req_valid_ff || advance);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign req_valid_in = req_fire || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         opcode_ff  <= req_ch.opcode;
         elapsed_ff <= req_ch.elapsed;
         channel_ff <= req_ch.channel;
         period_ff  <= req_ch.period_value;
      end
   end

   // configuration registers
   assign csr_ch.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff  <= METHOD_SLIDING;
         max_pos_ff <= MAX_POSITION_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_STEP_METHOD:  method_ff  <= csr_ch.data[0];
            CSR_MAX_POSITION: max_pos_ff <= csr_ch.data[POS_W-1:0];
            default: ;
         endcase
      end
   end

   // control broadcast to the channels
   always_comb begin
      ctrl.tick         = advance && (opcode_ff == OP_TICK);
      ctrl.set_period   = advance && (opcode_ff == OP_SET_PERIOD);
      ctrl.channel      = channel_ff;
      ctrl.step_method  = method_ff;
      ctrl.max_position = max_pos_ff;
      ctrl.elapsed      = elapsed_ff;
      ctrl.period_value = period_ff;
   end

   // channel units
   for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
      mcst_channel u_chan (
         .clock      (clock),
         .reset      (reset),
         .chan_id    (CH_W'(i)),
         .ctrl       (ctrl),
         .step_level (step_bits[i]),
         .direction  (dir_bits[i]),
         .led        (led_bits[i])
      );
   end

   // result: channel state holds until the next request advances
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.step_levels      = step_bits;
   assign rsp_ch.direction_levels = dir_bits;
   assign rsp_ch.led_levels       = led_bits;

endmodule : multi_channel_stepper_tone_engine

`default_nettype wire

// ===== sv/mcst_checker.sv =====
// mcst_checker: port-level assertions for the stepper tone engine
// depends on mcst_pkg; attached to the top level by the bind below
`default_nettype none

module mcst_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           req_valid,
   input wire                           req_ready,
   input wire                           rsp_valid,
   input wire                           rsp_ready,
   input wire [mcst_pkg::CHANNELS-1:0]  step_levels,
   input wire [mcst_pkg::CHANNELS-1:0]  direction_levels,
   input wire [mcst_pkg::CHANNELS-1:0]  led_levels
);
   import mcst_pkg::*;

   // reset empties the result side
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // no request is taken while reset is held
   a_no_accept_in_reset: assert property (@(posedge clock) reset |-> !req_ready)
      else $error("request ready during reset");

   // a fresh result always comes from a request that passed through the request register without a stall
   a_rise_from_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without matching request");

   // a stalled result holds its pin levels
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(step_levels)
         && $stable(direction_levels) && $stable(led_levels))
      else $error("stalled response changed");

endmodule : mcst_checker

bind multi_channel_stepper_tone_engine mcst_checker u_mcst_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .step_levels      (rsp_ch.step_levels),
   .direction_levels (rsp_ch.direction_levels),
   .led_levels       (rsp_ch.led_levels)
);

`default_nettype wire

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for the six-channel stepper tone engine
// holds a pin level predictor in a scoreboard class; drives request, response and csr channels
// depends on mcst_pkg, mcst_ifs and multi_channel_stepper_tone_engine
`default_nettype none

module tb_top;
   import mcst_pkg::*;

   typedef struct packed {
      logic                   opcode;
      logic [ELAPSED_W-1:0]   elapsed;
      logic [CH_W-1:0]        channel;
      logic [PERIOD_IN_W-1:0] period_value;
   } tone_request_type;

   typedef struct packed {
      logic [CHANNELS-1:0] step_lv;
      logic [CHANNELS-1:0] dir_lv;
      logic [CHANNELS-1:0] led_lv;
   } pin_levels_type;

   // predicts pin levels per request and checks responses in order
   class pin_level_board_type;
      logic [PERIOD_W-1:0] period_by_ch [CHANNELS];
      logic [COUNT_W-1:0]  count_by_ch [CHANNELS];
      logic [POS_W-1:0]    pos_by_ch [CHANNELS];
      logic [CHANNELS-1:0] step_bits;
      logic [CHANNELS-1:0] dir_bits;
      logic [CHANNELS-1:0] led_bits;
      logic                method_sel;
      logic [POS_W-1:0]    max_pos;
      pin_levels_type      expected_levels [$];
      int                  mismatch_count;

      function new();
         for (int i = 0; i < CHANNELS; i++) begin
            period_by_ch[i] = '0;
            count_by_ch[i] = '0;
            pos_by_ch[i] = '0;
         end
         step_bits = '0;
         dir_bits = '0;
         led_bits = '0;
         method_sel = METHOD_SLIDING;
         max_pos = MAX_POSITION_RESET;
         mismatch_count = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_STEP_METHOD)
            method_sel = val[0];
         else if (idx == CSR_MAX_POSITION)
            max_pos = val[POS_W-1:0];
      endfunction

      // one step of a channel in the active method
      function void step_channel(int i);
         if (method_sel == METHOD_OSCILLATING) begin
            if (step_bits[i])
               dir_bits[i] = ~dir_bits[i];
            step_bits[i] = ~step_bits[i];
         end else begin
            if (pos_by_ch[i] >= max_pos)
               dir_bits[i] = 1'b1;
            else if (pos_by_ch[i] == '0)
               dir_bits[i] = 1'b0;
            step_bits[i] = ~step_bits[i];
            // arm moves on the rising level, wrapping below zero
            if (step_bits[i])
               pos_by_ch[i] = dir_bits[i] ? pos_by_ch[i] - POS_W'(1) :
                                            pos_by_ch[i] + POS_W'(1);
         end
      endfunction

      function void note_request(tone_request_type r);
         logic [COUNT_W:0] sum;
         pin_levels_type   lv;
         if (r.opcode == OP_SET_PERIOD) begin
            // out-of-range channels leave everything alone
            if (r.channel < CHANNELS) begin
               period_by_ch[r.channel] = (method_sel == METHOD_OSCILLATING) ?
                  {1'b0, r.period_value} : {r.period_value, 1'b0};
               led_bits[r.channel] = (r.period_value != '0);
            end
         end else begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (period_by_ch[i] != '0) begin
                  // saturating elapsed count
                  sum = {1'b0, count_by_ch[i]} + (COUNT_W+1)'(r.elapsed);
                  count_by_ch[i] = (sum > COUNT_MAX) ? COUNT_MAX : sum[COUNT_W-1:0];
                  if (count_by_ch[i] >= COUNT_W'(period_by_ch[i])) begin
                     step_channel(i);
                     count_by_ch[i] = '0;
                  end
               end
            end
         end
         lv.step_lv = step_bits;
         lv.dir_lv = dir_bits;
         lv.led_lv = led_bits;
         expected_levels.push_back(lv);
      endfunction

      function void report(string field, logic [CHANNELS-1:0] exp_v, logic [CHANNELS-1:0] act_v);
         mismatch_count++;
         if (mismatch_count <= 100)
            $display("%0t mismatch %s expected %h actual %h", $time, field, exp_v, act_v);
      endfunction

      function void check_levels(pin_levels_type act);
         pin_levels_type exp_lv;
         if (expected_levels.size() == 0) begin
            mismatch_count++;
            $display("%0t unexpected response expected none actual %h", $time, act);
            return;
         end
         exp_lv = expected_levels.pop_front();
         if (act.step_lv !== exp_lv.step_lv)
            report("step_levels", exp_lv.step_lv, act.step_lv);
         if (act.dir_lv !== exp_lv.dir_lv)
            report("direction_levels", exp_lv.dir_lv, act.dir_lv);
         if (act.led_lv !== exp_lv.led_lv)
            report("led_levels", exp_lv.led_lv, act.led_lv);
      endfunction

      function int pending();
         return expected_levels.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic long_hold_due;

   mcst_req_if req_ch();
   mcst_rsp_if rsp_ch();
   mcst_csr_if csr_ch();

   pin_level_board_type score = new();

   // settings walked through, one per random phase
   logic       phase_method [8] = '{METHOD_OSCILLATING, METHOD_SLIDING, METHOD_SLIDING,
                                    METHOD_OSCILLATING, METHOD_SLIDING, METHOD_SLIDING,
                                    METHOD_SLIDING, METHOD_SLIDING};
   logic [7:0] phase_max [8] = '{8'd72, 8'd3, 8'd1, 8'd255, 8'd255, 8'd0, 8'd72, 8'd2};

   multi_channel_stepper_tone_engine dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #3000000;
      $display("TB_ERROR");
      $finish;
   end

   // drive one request and hold it until accepted
   task automatic send_request(tone_request_type r);
      req_ch.valid <= 1'b1;
      req_ch.opcode <= r.opcode;
      req_ch.elapsed <= r.elapsed;
      req_ch.channel <= r.channel;
      req_ch.period_value <= r.period_value;
      do @(posedge clock); while (!req_ch.ready);
      score.note_request(r);
   endtask

   task automatic tick_request(logic [ELAPSED_W-1:0] e);
      tone_request_type r;
      r.opcode = OP_TICK;
      r.elapsed = e;
      r.channel = CH_W'($urandom());
      r.period_value = PERIOD_IN_W'($urandom());
      send_request(r);
   endtask

   task automatic period_request(logic [CH_W-1:0] ch, logic [PERIOD_IN_W-1:0] v);
      tone_request_type r;
      r.opcode = OP_SET_PERIOD;
      r.elapsed = ELAPSED_W'($urandom());
      r.channel = ch;
      r.period_value = v;
      send_request(r);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      score.write_register(idx, val);
   endtask

   // stop offering and wait for every expected response
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (score.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // mostly short periods and deltas so channels step often
   function automatic tone_request_type random_request();
      tone_request_type r;
      int               pick;
      r.opcode = ($urandom_range(99) < 25) ? OP_SET_PERIOD : OP_TICK;
      pick = $urandom_range(9);
      if (pick <= 6)
         r.elapsed = ELAPSED_W'($urandom_range(40));
      else if (pick == 7)
         r.elapsed = '0;
      else if (pick == 8)
         r.elapsed = ELAPSED_W'($urandom());
      else
         r.elapsed = ELAPSED_W'($urandom_range(600, 40));
      r.channel = ($urandom_range(9) == 0) ? CH_W'($urandom_range(7, 6)) :
                                             CH_W'($urandom_range(5));
      pick = $urandom_range(9);
      if (pick <= 5)
         r.period_value = PERIOD_IN_W'($urandom_range(20, 1));
      else if (pick == 6)
         r.period_value = '0;
      else if (pick == 7)
         r.period_value = PERIOD_IN_W'($urandom_range(300, 21));
      else if (pick == 8)
         r.period_value = PERIOD_IN_W'($urandom());
      else
         r.period_value = '1;
      return r;
   endfunction

   // random requests in bursts with random gaps
   task automatic run_random(int count);
      int sent;
      int burst;
      int gap;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(16, 1);
         for (int k = 0; k < burst && sent < count; k++) begin
            send_request(random_request());
            sent++;
         end
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // response side: checks each accepted response and stalls on its own pattern
   initial begin
      int   hold_left;
      int   cyc;
      logic rdy;
      hold_left = 0;
      cyc = 0;
      long_hold_due <= 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready)
            score.check_levels({rsp_ch.step_levels, rsp_ch.direction_levels,
                                rsp_ch.led_levels});
         if (long_hold_due) begin
            long_hold_due <= 1'b0;
            hold_left = 300;
         end
         cyc++;
         if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
         end else begin
            case ((cyc / 50) % 4)
               0: rdy = 1'b1;
               1: rdy = 1'($urandom_range(1));
               2: rdy = ($urandom_range(3) == 0);
               default: rdy = (cyc % 8 != 0);
            endcase
         end
         rsp_ch.ready <= rdy;
      end
   end

   // stimulus
   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.opcode <= OP_TICK;
      req_ch.elapsed <= '0;
      req_ch.channel <= '0;
      req_ch.period_value <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= CSR_STEP_METHOD;
      csr_ch.data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, field extremes, ignored channels, stopped channels
      tick_request('0);
      period_request(3'd0, 20'd1);
      period_request(3'd5, '1);
      period_request(3'd6, 20'd5);
      period_request(3'd7, '1);
      period_request(3'd1, '0);
      tick_request('1);
      tick_request(16'd1);
      tick_request('0);
      period_request(3'd2, 20'd3);
      period_request(3'd3, 20'hAAAAA);
      period_request(3'd4, 20'h55555);
      tick_request(16'hAAAA);
      tick_request(16'h5555);
      period_request(3'd0, '0);
      tick_request(16'd7);
      // a shorter period below the running count steps on a zero tick
      period_request(3'd2, 20'd100);
      tick_request(16'd150);
      period_request(3'd2, 20'd50);
      tick_request('0);
      tick_request(16'd3);

      // random phases, each under its own register settings
      for (int ph = 0; ph < 8; ph++) begin
         drain();
         write_register(CSR_STEP_METHOD, {7'd0, phase_method[ph]});
         write_register(CSR_MAX_POSITION, phase_max[ph]);
         @(posedge clock);
         if (ph == 2)
            long_hold_due <= 1'b1;
         run_random(105);
      end
      drain();
      repeat (10) @(posedge clock);

      if (score.mismatch_count == 0 && score.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule : tb_top

`default_nettype wire
